>>> hw/rtl/polyd_pkg.sv
// Package for the polygon boundary distance core.
// Holds the edge flag word, the back-end state codes and default sizes.
// No dependencies.
`default_nettype none
package polyd_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int QUEUE_DEPTH    = 4;

   // Per-edge control carried through the queue with the coordinates.
   typedef struct packed {
      logic start;   // first edge of a polygon: minimum restarts
      logic emit;    // closing edge: result word follows the update
   } edge_flags_type;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_DIFF   = 8'b0000_0010,
      ST_PROD   = 8'b0000_0100,
      ST_SUM    = 8'b0000_1000,
      ST_SQR    = 8'b0001_0000,
      ST_SQSUM  = 8'b0010_0000,
      ST_DIV    = 8'b0100_0000,
      ST_UPDATE = 8'b1000_0000
   } back_state_type;

endpackage
`default_nettype wire

>>> hw/rtl/polygon_min_dist_sqrd_core.sv
// Smallest squared distance from a query point to a polygon boundary. Vertices
// arrive one word each; the query point is taken from the first vertex word of a
// polygon, and the word marked last closes the polygon and yields one result word.
// The front takes a vertex word per cycle unless the queue is full; it stalls after
// a polygon's last word while it issues the closing edge. The back works one edge
// at a time in diff, product, sum, square and update steps; when the nearest point
// is no endpoint, a squared sum and a one-bit-a-cycle divider of the cross term by
// the length precede the update. A four-entry queue lets the front run ahead.
// Depends on polyd_pkg, polyd_front, polyd_queue and polyd_back.
`default_nettype none
module polygon_min_dist_sqrd_core
   import polyd_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [COORD_BITS-1:0] req_query_x,
   input  wire logic signed [COORD_BITS-1:0] req_query_y,
   input  wire logic signed [COORD_BITS-1:0] req_vertex_x,
   input  wire logic signed [COORD_BITS-1:0] req_vertex_y,
   input  wire logic                         req_last_vertex,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [2*COORD_BITS:0]             rsp_nearest_dist
);
   localparam int C  = COORD_BITS;
   localparam int TW = 6 * C + $bits(edge_flags_type);

   logic           push, pop, full, empty;
   edge_flags_type f_flags, b_flags;
   logic signed [C-1:0] f_qx, f_qy, f_sx, f_sy, f_ex, f_ey;
   logic [TW-1:0]  push_word, pop_word;

   polyd_front #(.COORD_BITS(C)) u_front (
      .clock, .reset, .req_valid, .req_stall,
      .req_query_x, .req_query_y, .req_vertex_x, .req_vertex_y, .req_last_vertex,
      .queue_full(full), .edge_push(push), .edge_flags(f_flags),
      .edge_qx(f_qx), .edge_qy(f_qy), .edge_sx(f_sx), .edge_sy(f_sy),
      .edge_ex(f_ex), .edge_ey(f_ey)
   );

   assign push_word = {f_flags, f_qx, f_qy, f_sx, f_sy, f_ex, f_ey};

   polyd_queue #(.WIDTH(TW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset, .push, .push_data(push_word), .pop, .pop_data(pop_word),
      .full, .empty
   );

   assign b_flags = pop_word[TW-1:6*C];

   polyd_back #(.COORD_BITS(C)) u_back (
      .clock, .reset, .queue_empty(empty), .queue_pop(pop), .edge_flags(b_flags),
      .edge_qx($signed(pop_word[6*C-1:5*C])), .edge_qy($signed(pop_word[5*C-1:4*C])),
      .edge_sx($signed(pop_word[4*C-1:3*C])), .edge_sy($signed(pop_word[3*C-1:2*C])),
      .edge_ex($signed(pop_word[2*C-1:C])),   .edge_ey($signed(pop_word[C-1:0])),
      .rsp_valid, .rsp_stall, .rsp_nearest_dist
   );
endmodule
`default_nettype wire

>>> hw/rtl/polyd_queue.sv
// Short register queue between the front and back parts of the core.
// Generic width and depth; depends on nothing else.
`default_nettype none
module polyd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  full,
   output logic                  empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/polyd_front.sv
// Front part: takes vertex words, tracks the polygon and issues edges.
// Depends on polyd_pkg for the edge flag word.
`default_nettype none
module polyd_front
   import polyd_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [COORD_BITS-1:0] req_query_x,
   input  wire logic signed [COORD_BITS-1:0] req_query_y,
   input  wire logic signed [COORD_BITS-1:0] req_vertex_x,
   input  wire logic signed [COORD_BITS-1:0] req_vertex_y,
   input  wire logic                         req_last_vertex,
   input  wire logic                         queue_full,
   output logic                              edge_push,
   output edge_flags_type                    edge_flags,
   output logic signed [COORD_BITS-1:0]      edge_qx,
   output logic signed [COORD_BITS-1:0]      edge_qy,
   output logic signed [COORD_BITS-1:0]      edge_sx,
   output logic signed [COORD_BITS-1:0]      edge_sy,
   output logic signed [COORD_BITS-1:0]      edge_ex,
   output logic signed [COORD_BITS-1:0]      edge_ey
);
   logic signed [COORD_BITS-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic signed [COORD_BITS-1:0] held_qx_ff, held_qy_ff;
   logic mid_ff, mid_in, start_pend_ff, start_pend_in, close_pend_ff, close_pend_in;
   logic accept;

   // The closing edge follows the last vertex once the queue has room.
   assign req_stall = close_pend_ff || queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      edge_push     = 1'b0;
      edge_flags    = '0;
      edge_qx       = held_qx_ff;
      edge_qy       = held_qy_ff;
      edge_sx       = prev_x_ff;
      edge_sy       = prev_y_ff;
      edge_ex       = req_vertex_x;
      edge_ey       = req_vertex_y;
      mid_in        = mid_ff;
      start_pend_in = start_pend_ff;
      close_pend_in = close_pend_ff;
      if (close_pend_ff) begin
         edge_ex    = first_x_ff;
         edge_ey    = first_y_ff;
         edge_flags.emit = 1'b1;
         if (!queue_full) begin
            edge_push     = 1'b1;
            close_pend_in = 1'b0;
         end
      end else if (accept) begin
         if (!mid_ff) begin
            if (req_last_vertex) begin
               // A lone vertex: the degenerate edge gives its point distance.
               edge_push       = 1'b1;
               edge_flags      = '{start: 1'b1, emit: 1'b1};
               edge_qx         = req_query_x;
               edge_qy         = req_query_y;
               edge_sx         = req_vertex_x;
               edge_sy         = req_vertex_y;
            end else begin
               mid_in        = 1'b1;
               start_pend_in = 1'b1;
            end
         end else begin
            edge_push        = 1'b1;
            edge_flags.start = start_pend_ff;
            start_pend_in    = 1'b0;
            if (req_last_vertex) begin
               mid_in        = 1'b0;
               close_pend_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff        <= 1'b0;
         start_pend_ff <= 1'b0;
         close_pend_ff <= 1'b0;
      end else begin
         mid_ff        <= mid_in;
         start_pend_ff <= start_pend_in;
         close_pend_ff <= close_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prev_x_ff <= req_vertex_x;
         prev_y_ff <= req_vertex_y;
         if (!mid_ff) begin
            first_x_ff <= req_vertex_x;
            first_y_ff <= req_vertex_y;
            held_qx_ff <= req_query_x;
            held_qy_ff <= req_query_y;
         end
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/polyd_back.sv
// Back part: squared point-to-segment distance per edge and the running minimum.
// Depends on polyd_pkg; holds the squaring steps and a bit-serial divider.
`default_nettype none
module polyd_back
   import polyd_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          queue_empty,
   output logic                               queue_pop,
   input  wire edge_flags_type                edge_flags,
   input  wire logic signed [COORD_BITS-1:0]  edge_qx,
   input  wire logic signed [COORD_BITS-1:0]  edge_qy,
   input  wire logic signed [COORD_BITS-1:0]  edge_sx,
   input  wire logic signed [COORD_BITS-1:0]  edge_sy,
   input  wire logic signed [COORD_BITS-1:0]  edge_ex,
   input  wire logic signed [COORD_BITS-1:0]  edge_ey,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [2*COORD_BITS:0]              rsp_nearest_dist
);
   localparam int C  = COORD_BITS;
   localparam int DW = 2 * C + 2;    // distances, edge length, quotient
   localparam int SW = 2 * C + 3;    // signed sums
   localparam int H  = C + 1;        // half width of the cross magnitude
   localparam int NW = 4 * H;        // squared cross magnitude
   localparam int KW = $clog2(DW);

   back_state_type state_ff, state_in;
   edge_flags_type flags_ff;
   logic signed [C-1:0] qx_ff, qy_ff, sx_ff, sy_ff, ex_ff, ey_ff;
   logic signed [C:0]   vx_ff, vy_ff, ux_ff, uy_ff, wx_ff, wy_ff;
   logic signed [2*C+1:0] p_vxux_ff, p_vyuy_ff, p_uxux_ff, p_uyuy_ff;
   logic signed [2*C+1:0] p_vxvx_ff, p_vyvy_ff, p_wxwx_ff, p_wywy_ff;
   logic signed [2*C+1:0] p_uxvy_ff, p_uyvx_ff;
   logic signed [SW-1:0]  dot_ff, cross_s;
   logic [DW-1:0] len_ff, dv_ff, dw_ff, mag_ff, mag_in, dist_ff;
   logic [2*H-1:0] pp_hh_ff, pp_hl_ff, pp_ll_ff;
   logic [NW-1:0]  num_s;
   logic [DW-1:0]  rem_ff, quo_ff;
   logic [DW:0]    rem_shift;
   logic           rem_ge;
   logic [KW-1:0]  count_ff;
   logic [DW-1:0]  min_ff, cand;
   logic           rsp_valid_ff, blocked;
   logic [2*C:0]   rsp_data_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_nearest_dist = rsp_data_ff;
   assign queue_pop        = (state_ff == ST_IDLE) && !queue_empty;

   assign cross_s = SW'(p_uxvy_ff) - SW'(p_uyvx_ff);
   assign mag_in  = cross_s[SW-1] ? DW'(-cross_s) : DW'(cross_s);
   assign num_s   = (NW'(pp_hh_ff) << (2 * H)) + (NW'(pp_hl_ff) << (H + 1))
                  + NW'(pp_ll_ff);

   assign rem_shift = {rem_ff, quo_ff[DW-1]};
   assign rem_ge    = (rem_shift >= {1'b0, len_ff});

   assign cand    = flags_ff.start ? dist_ff : ((dist_ff < min_ff) ? dist_ff : min_ff);
   assign blocked = flags_ff.emit && rsp_valid_ff && rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (!queue_empty) state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_PROD;
         ST_PROD:   state_in = ST_SUM;
         ST_SUM:    state_in = ST_SQR;
         ST_SQR: begin
            if (dot_ff <= 0 || dot_ff >= $signed({1'b0, len_ff})) begin
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_SQSUM;
            end
         end
         ST_SQSUM:  state_in = ST_DIV;
         ST_DIV:    if (count_ff == '0) state_in = ST_UPDATE;
         ST_UPDATE: if (!blocked) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_UPDATE && !blocked) begin
            min_ff <= cand;
         end
         if (state_ff == ST_UPDATE && !blocked && flags_ff.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            flags_ff <= edge_flags;
            qx_ff <= edge_qx;
            qy_ff <= edge_qy;
            sx_ff <= edge_sx;
            sy_ff <= edge_sy;
            ex_ff <= edge_ex;
            ey_ff <= edge_ey;
         end
         ST_DIFF: begin
            vx_ff <= {qx_ff[C-1], qx_ff} - {sx_ff[C-1], sx_ff};
            vy_ff <= {qy_ff[C-1], qy_ff} - {sy_ff[C-1], sy_ff};
            ux_ff <= {ex_ff[C-1], ex_ff} - {sx_ff[C-1], sx_ff};
            uy_ff <= {ey_ff[C-1], ey_ff} - {sy_ff[C-1], sy_ff};
            wx_ff <= {ex_ff[C-1], ex_ff} - {qx_ff[C-1], qx_ff};
            wy_ff <= {ey_ff[C-1], ey_ff} - {qy_ff[C-1], qy_ff};
         end
         ST_PROD: begin
            p_vxux_ff <= vx_ff * ux_ff;
            p_vyuy_ff <= vy_ff * uy_ff;
            p_uxux_ff <= ux_ff * ux_ff;
            p_uyuy_ff <= uy_ff * uy_ff;
            p_vxvx_ff <= vx_ff * vx_ff;
            p_vyvy_ff <= vy_ff * vy_ff;
            p_wxwx_ff <= wx_ff * wx_ff;
            p_wywy_ff <= wy_ff * wy_ff;
            p_uxvy_ff <= ux_ff * vy_ff;
            p_uyvx_ff <= uy_ff * vx_ff;
         end
         ST_SUM: begin
            dot_ff <= SW'(p_vxux_ff) + SW'(p_vyuy_ff);
            len_ff <= DW'(p_uxux_ff) + DW'(p_uyuy_ff);
            dv_ff  <= DW'(p_vxvx_ff) + DW'(p_vyvy_ff);
            dw_ff  <= DW'(p_wxwx_ff) + DW'(p_wywy_ff);
            mag_ff <= mag_in;
         end
         ST_SQR: begin
            // Start point, end point, or the cross term squared in halves.
            if (dot_ff <= 0) begin
               dist_ff <= dv_ff;
            end else begin
               dist_ff <= dw_ff;
            end
            pp_hh_ff <= mag_ff[DW-1:H] * mag_ff[DW-1:H];
            pp_hl_ff <= mag_ff[DW-1:H] * mag_ff[H-1:0];
            pp_ll_ff <= mag_ff[H-1:0] * mag_ff[H-1:0];
         end
         ST_SQSUM: begin
            // The quotient fits in DW bits, so the upper half is below the divisor.
            rem_ff   <= num_s[NW-1:DW];
            quo_ff   <= num_s[DW-1:0];
            count_ff <= KW'(DW - 1);
         end
         ST_DIV: begin
            rem_ff   <= rem_ge ? DW'(rem_shift - {1'b0, len_ff}) : rem_shift[DW-1:0];
            quo_ff   <= {quo_ff[DW-2:0], rem_ge};
            count_ff <= count_ff - KW'(1);
            if (count_ff == '0) begin
               dist_ff <= {quo_ff[DW-2:0], rem_ge};
            end
         end
         ST_UPDATE: begin
            if (!blocked && flags_ff.emit) begin
               rsp_data_ff <= cand[2*C:0];
            end
         end
         default: begin
         end
      endcase
   end
endmodule
`default_nettype wire
